@@ design/u8d_pkg.sv @@
package u8d_pkg;

	localparam int CP_W   = 21;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 2;
	localparam int LEN_W  = 3;
	localparam int RUN_W  = 3;

	// Replacement character for bad bytes and broken sequences.
	localparam logic [CP_W-1:0] QMARK = 21'h00003F;

	// Sequence lengths set by the lead byte.
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic load;     // take the input word and build its result run
		logic advance;  // the current result word was taken
	} cmd_t;

	typedef struct packed {
		logic any_result;  // the input word on the port yields at least one result
		logic last;        // the result word on the port ends its run
		logic held_empty;  // no partial sequence pending
	} status_t;

endpackage

@@ design/u8d_ctrl.sv @@
module u8d_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output u8d_pkg::cmd_t    cmd,
	input  u8d_pkg::status_t st
);
	import u8d_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				if (in_valid && st.any_result) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid   = 1'b1;
				cmd.advance = !out_stall;
				if (!out_stall && st.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/u8d_datapath.sv @@
module u8d_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        end_of_string,
	input  u8d_pkg::cmd_t               cmd,
	output u8d_pkg::status_t            st,
	output logic [u8d_pkg::CP_W-1:0]    code_point,
	output logic                        last_of_run
);
	import u8d_pkg::*;

	logic [BYTE_W-1:0] held_q [3];
	logic [CNT_W-1:0]  held_count_q;
	logic [LEN_W-1:0]  seq_len_q;

	// Result run: pre '?' words, at most one middle word, post '?' words.
	logic [RUN_W-1:0]  rem_q;
	logic [RUN_W-1:0]  mid_rem_q;
	logic              mid_en_q;
	logic [CP_W-1:0]   mid_val_q;

	logic              is_ascii, is_l2, is_l3, is_l4, is_cont, complete, lead_path;
	logic [CP_W-1:0]   cp_full;
	logic [CNT_W-1:0]  pre, post, nxt_count, fin_count, wr_idx;
	logic [LEN_W-1:0]  nxt_len, fin_len;
	logic              mid_en, wr_en;
	logic [CP_W-1:0]   mid_val;
	logic [RUN_W-1:0]  total;

	assign is_ascii = !in_byte[7];
	assign is_l2    = in_byte[7:5] == 3'b110;
	assign is_l3    = in_byte[7:4] == 4'b1110;
	assign is_l4    = in_byte[7:3] == 5'b11110;
	assign is_cont  = in_byte[7:6] == 2'b10;
	assign complete = (({1'b0, held_count_q} + 3'd1) >= seq_len_q) || (held_count_q == 2'd3);

	always_comb begin
		unique case (seq_len_q)
			LEN_TWO:   cp_full = {10'd0, held_q[0][4:0], in_byte[5:0]};
			LEN_THREE: cp_full = {5'd0, held_q[0][3:0], held_q[1][5:0], in_byte[5:0]};
			default:   cp_full = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
				in_byte[5:0]};
		endcase
	end

	always_comb begin
		pre       = '0;
		mid_en    = 1'b0;
		mid_val   = QMARK;
		nxt_count = held_count_q;
		nxt_len   = seq_len_q;
		wr_en     = 1'b0;
		wr_idx    = held_count_q;
		lead_path = 1'b0;
		if (held_count_q == '0) begin
			lead_path = 1'b1;
		end else if (is_cont) begin
			if (complete) begin
				mid_en    = 1'b1;
				mid_val   = cp_full;
				nxt_count = '0;
				nxt_len   = LEN_NONE;
			end else begin
				wr_en     = 1'b1;
				nxt_count = held_count_q + 2'd1;
			end
		end else begin
			// broken sequence: one '?' per held byte, then retry the byte as a lead
			pre       = held_count_q;
			nxt_count = '0;
			nxt_len   = LEN_NONE;
			lead_path = 1'b1;
		end
		if (lead_path) begin
			if (is_ascii) begin
				mid_en  = 1'b1;
				mid_val = {{(CP_W-BYTE_W){1'b0}}, in_byte};
			end else if (is_l2 || is_l3 || is_l4) begin
				wr_en     = 1'b1;
				wr_idx    = '0;
				nxt_count = 2'd1;
				priority if (is_l2) nxt_len = LEN_TWO;
				else if (is_l3)     nxt_len = LEN_THREE;
				else                nxt_len = LEN_FOUR;
			end else begin
				mid_en  = 1'b1;
				mid_val = QMARK;
			end
		end
		post      = end_of_string ? nxt_count : '0;
		fin_count = end_of_string ? '0 : nxt_count;
		fin_len   = end_of_string ? LEN_NONE : nxt_len;
		total     = {1'b0, pre} + {2'b0, mid_en} + {1'b0, post};
	end

	// Held bytes carry no reset; only entries below the count are read.
	always_ff @(posedge clk) begin
		if (cmd.load && wr_en) begin
			held_q[wr_idx] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			seq_len_q    <= LEN_NONE;
			rem_q        <= '0;
		end else if (cmd.load) begin
			held_count_q <= fin_count;
			seq_len_q    <= fin_len;
			rem_q        <= total;
		end else if (cmd.advance) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mid_en_q  <= mid_en;
			mid_val_q <= mid_val;
			mid_rem_q <= {1'b0, post} + 3'd1;
		end
	end

	assign code_point    = (mid_en_q && rem_q == mid_rem_q) ? mid_val_q : QMARK;
	assign last_of_run   = rem_q == 3'd1;
	assign st.any_result = total != '0;
	assign st.last       = rem_q == 3'd1;
	assign st.held_empty = held_count_q == '0;

endmodule

@@ design/utf8_byte_stream_decoder.sv @@
// Channel  Direction  Handshake            Word
// in       sink       in_valid/in_stall    in_byte[7:0], end_of_string
// out      source     out_valid/out_stall  code_point[20:0], last_of_run
//
// A byte that only extends a pending sequence is taken without leaving idle.
// A byte that yields n results (1 to 4) is taken and builds its result run,
// then the run registers give out the result words in turn.
// The input stalls while a run drains; out_stall holds the current word.
// arst_n clears the controller, the held count and the sequence length.
module utf8_byte_stream_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
	input  logic                       end_of_string,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [u8d_pkg::CP_W-1:0]   code_point,
	output logic                       last_of_run
);
	import u8d_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Controller: take a byte, then drain its result run word by word.
	u8d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st)
	);

	// Datapath: held sequence bytes, lead classification, code point assembly
	// and the result run counters.
	u8d_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.cmd           (cmd),
		.st            (st),
		.code_point    (code_point),
		.last_of_run   (last_of_run)
	);

	// No new byte while a run is still draining.
	a_no_take_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while results pending");

	// A run ends after its last word is taken.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_run) |=> !out_valid)
		else $error("output still valid after last word");

	// A run continues until its last word.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_run) |=> out_valid)
		else $error("run dropped before last word");

	// End of string leaves no pending sequence.
	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && end_of_string) |=> st.held_empty)
		else $error("bytes still held after end of string");

endmodule
